// ===== sv/pteb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pteb_pkg
// Types, constants and fixed-point helpers for the particle integrator with
// tank wall bounce.
// ----------------------------------------------------------------------------
package pteb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int REST_BITS     = 16;
  localparam int DATA_W        = 32;
  localparam int DT_W          = 17;
  localparam int REST_W        = 17;
  localparam int RADIUS_W      = 31;
  localparam int MUL_W         = DATA_W + DT_W + 1;
  localparam int SUM_W         = MUL_W + 2;
  localparam int ADDR_W        = 5;

  localparam logic [DT_W-1:0]            TIME_STEP_RST = DT_W'(546);
  localparam logic signed [DATA_W-1:0]   WALL_X_MIN_RST = DATA_W'(0);
  localparam logic signed [DATA_W-1:0]   WALL_X_MAX_RST = DATA_W'(655360);
  localparam logic signed [DATA_W-1:0]   WALL_Y_MIN_RST = DATA_W'(0);
  localparam logic signed [DATA_W-1:0]   WALL_Y_MAX_RST = DATA_W'(655360);
  localparam logic signed [DATA_W-1:0]   FLOOR_Z_RST    = DATA_W'(0);
  localparam logic [RADIUS_W-1:0]        RADIUS_RST     = RADIUS_W'(13107);
  localparam logic [REST_W-1:0]          REST_RST       = REST_W'(3277);

  localparam logic signed [SUM_W-1:0] S32_MAX_W = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] S32_MIN_W = SUM_W'(-64'sd2147483648);

  typedef enum logic [2:0] {
    REG_TIME_STEP  = 3'd0,
    REG_WALL_X_MIN = 3'd1,
    REG_WALL_X_MAX = 3'd2,
    REG_WALL_Y_MIN = 3'd3,
    REG_WALL_Y_MAX = 3'd4,
    REG_FLOOR_Z    = 3'd5,
    REG_RADIUS     = 3'd6,
    REG_RESTITUTION = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] acc_x;
    logic signed [DATA_W-1:0] acc_y;
    logic signed [DATA_W-1:0] acc_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_pos_z;
    logic signed [DATA_W-1:0] new_vel_x;
    logic signed [DATA_W-1:0] new_vel_y;
    logic signed [DATA_W-1:0] new_vel_z;
  } out_item_t;

  typedef struct packed {
    logic [DT_W-1:0]          dt;
    logic [REST_W-1:0]        rest;
    logic signed [DATA_W-1:0] lim_x_lo;
    logic signed [DATA_W-1:0] lim_x_hi;
    logic signed [DATA_W-1:0] lim_y_lo;
    logic signed [DATA_W-1:0] lim_y_hi;
    logic signed [DATA_W-1:0] lim_z_lo;
  } cfg_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > S32_MAX_W) begin
      r = S32_MAX_W[DATA_W-1:0];
    end else if (v < S32_MIN_W) begin
      r = S32_MIN_W[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // signed 32 by unsigned 17 product
  function automatic logic signed [MUL_W-1:0] mul_u17(input logic signed [DATA_W-1:0] a,
                                                      input logic [DT_W-1:0] b);
    logic signed [DT_W:0] bs;
    bs = $signed({1'b0, b});
    return a * bs;
  endfunction

  // floor(p / 2^16), negated, saturated
  function automatic logic signed [DATA_W-1:0] bounce(input logic signed [MUL_W-1:0] p);
    logic signed [SUM_W-1:0] w;
    w = SUM_W'(p);
    w = w >>> REST_BITS;
    return sat32(-w);
  endfunction

endpackage
`default_nettype wire

// ===== sv/pteb_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pteb_in_if
// Valid/ready channel carrying one particle state per transaction.
// ----------------------------------------------------------------------------
interface pteb_in_if;
  logic               valid;
  logic               ready;
  pteb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pteb_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pteb_out_if
// Valid/ready channel carrying one updated particle per transaction.
// ----------------------------------------------------------------------------
interface pteb_out_if;
  logic                valid;
  logic                ready;
  pteb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/particle_euler_tank_bounce.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// particle_euler_tank_bounce
// Symplectic Euler step of one particle followed by clamping and bounce
// against the floor and the four side walls of an open tank.
//
//   channel   | role   | payload
//   ----------+--------+--------------------------------------------
//   particle  | sink   | pos, vel, acc (x, y, z), signed Q16.16
//   result    | source | new_pos, new_vel (x, y, z), signed Q16.16
//   apb       | slave  | eight config registers, 32-bit data
//
// One transaction per cycle unless the result side stalls; eight register stages
// (a*dt, velocity sum, v*dt, position sum, clamp, first bounce, second
// bounce product, second bounce). Each stage holds only while the stage
// after it is full and stalled, so bubbles fill up under backpressure.
// Reset is synchronous and clears stage valid bits and config registers.
// ----------------------------------------------------------------------------
module particle_euler_tank_bounce #(
  parameter int FRAC_BITS = pteb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pteb_in_if.sink                          particle,
  pteb_out_if.source                       result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pteb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import pteb_pkg::*;

  cfg_t cfg;

  logic [8:1] vld;
  logic [9:1] go;

  logic signed [DATA_W-1:0] in_pos [3];
  logic signed [DATA_W-1:0] in_vel [3];
  logic signed [DATA_W-1:0] in_acc [3];

  logic signed [DATA_W-1:0] s1_pos  [3];
  logic signed [DATA_W-1:0] s1_vel  [3];
  logic signed [MUL_W-1:0]  s1_prod [3];
  logic signed [DATA_W-1:0] s2_pos  [3];
  logic signed [DATA_W-1:0] s2_vel  [3];
  logic signed [DATA_W-1:0] s3_pos  [3];
  logic signed [DATA_W-1:0] s3_vel  [3];
  logic signed [MUL_W-1:0]  s3_prod [3];
  logic signed [DATA_W-1:0] s4_pos  [3];
  logic signed [DATA_W-1:0] s4_vel  [3];
  logic signed [DATA_W-1:0] s5_pos  [3];
  logic signed [DATA_W-1:0] s5_vel  [3];
  logic signed [MUL_W-1:0]  s5_prod [3];
  logic [2:0]               s5_lo;
  logic [2:0]               s5_hi;
  logic signed [DATA_W-1:0] s6_pos  [3];
  logic signed [DATA_W-1:0] s6_vel  [3];
  logic [2:0]               s6_hi;
  logic signed [DATA_W-1:0] s7_pos  [3];
  logic signed [DATA_W-1:0] s7_vel  [3];
  logic signed [MUL_W-1:0]  s7_prod [3];
  logic [2:0]               s7_hi;
  logic signed [DATA_W-1:0] s8_pos  [3];
  logic signed [DATA_W-1:0] s8_vel  [3];

  logic signed [DATA_W-1:0] lim_lo [3];
  logic signed [DATA_W-1:0] lim_hi [3];
  logic [2:0]               has_hi;
  logic signed [DATA_W-1:0] c_pos  [3];
  logic [2:0]               c_lo;
  logic [2:0]               c_hi;

  pteb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage handshake: a stage advances when empty or when its successor does
  always_comb begin
    go[9] = result.ready;
    for (int k = 8; k >= 1; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
  end

  assign particle.ready = go[1];
  assign result.valid   = vld[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[1]) begin
        vld[1] <= particle.valid;
      end
      for (int k = 2; k <= 8; k++) begin
        if (go[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    in_pos[0] = particle.data.pos_x;
    in_pos[1] = particle.data.pos_y;
    in_pos[2] = particle.data.pos_z;
    in_vel[0] = particle.data.vel_x;
    in_vel[1] = particle.data.vel_y;
    in_vel[2] = particle.data.vel_z;
    in_acc[0] = particle.data.acc_x;
    in_acc[1] = particle.data.acc_y;
    in_acc[2] = particle.data.acc_z;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (go[1]) begin
        s1_pos[i]  <= in_pos[i];
        s1_vel[i]  <= in_vel[i];
        s1_prod[i] <= mul_u17(in_acc[i], cfg.dt);
      end
      if (go[2]) begin
        s2_pos[i] <= s1_pos[i];
        s2_vel[i] <= sat32(SUM_W'(s1_vel[i]) + (SUM_W'(s1_prod[i]) >>> FRAC_BITS));
      end
      if (go[3]) begin
        s3_pos[i]  <= s2_pos[i];
        s3_vel[i]  <= s2_vel[i];
        s3_prod[i] <= mul_u17(s2_vel[i], cfg.dt);
      end
      if (go[4]) begin
        s4_pos[i] <= sat32(SUM_W'(s3_pos[i]) + (SUM_W'(s3_prod[i]) >>> FRAC_BITS));
        s4_vel[i] <= s3_vel[i];
      end
    end
  end

  // wall limits per axis; z has a floor only
  always_comb begin
    lim_lo[0] = cfg.lim_x_lo;
    lim_lo[1] = cfg.lim_y_lo;
    lim_lo[2] = cfg.lim_z_lo;
    lim_hi[0] = cfg.lim_x_hi;
    lim_hi[1] = cfg.lim_y_hi;
    lim_hi[2] = cfg.lim_z_lo;
    has_hi    = 3'b011;
    for (int i = 0; i < 3; i++) begin
      c_lo[i]  = s4_pos[i] < lim_lo[i];
      c_pos[i] = c_lo[i] ? lim_lo[i] : s4_pos[i];
      c_hi[i]  = has_hi[i] && (c_pos[i] > lim_hi[i]);
      if (c_hi[i]) begin
        c_pos[i] = lim_hi[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (go[5]) begin
        s5_pos[i]  <= c_pos[i];
        s5_vel[i]  <= s4_vel[i];
        s5_prod[i] <= mul_u17(s4_vel[i], cfg.rest);
        s5_lo[i]   <= c_lo[i];
        s5_hi[i]   <= c_hi[i];
      end
      if (go[6]) begin
        s6_pos[i] <= s5_pos[i];
        s6_hi[i]  <= s5_hi[i];
        s6_vel[i] <= (s5_lo[i] && s5_vel[i] < 0) ? bounce(s5_prod[i]) : s5_vel[i];
      end
      if (go[7]) begin
        s7_pos[i]  <= s6_pos[i];
        s7_vel[i]  <= s6_vel[i];
        s7_hi[i]   <= s6_hi[i];
        s7_prod[i] <= mul_u17(s6_vel[i], cfg.rest);
      end
      if (go[8]) begin
        s8_pos[i] <= s7_pos[i];
        s8_vel[i] <= (s7_hi[i] && s7_vel[i] > 0) ? bounce(s7_prod[i]) : s7_vel[i];
      end
    end
  end

  assign result.data.new_pos_x = s8_pos[0];
  assign result.data.new_pos_y = s8_pos[1];
  assign result.data.new_pos_z = s8_pos[2];
  assign result.data.new_vel_x = s8_vel[0];
  assign result.data.new_vel_y = s8_vel[1];
  assign result.data.new_vel_z = s8_vel[2];

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !particle.ready |-> vld[1])
    else $error("input stalled with first stage empty");

  a_floor_holds: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.new_pos_z >= cfg.lim_z_lo)
    else $error("result below floor limit");

  a_x_max_wins: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.new_pos_x <= cfg.lim_x_hi)
    else $error("result beyond x max limit");

  a_y_max_wins: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.new_pos_y <= cfg.lim_y_hi)
    else $error("result beyond y max limit");

  a_out_from_stage7: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(vld[7]))
    else $error("result appeared without a predecessor stage");

endmodule
`default_nettype wire

// ===== sv/pteb_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pteb_regs
// APB register file for step, walls, radius and restitution; derives the
// saturated clamp limits for the datapath.
// ----------------------------------------------------------------------------
module pteb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pteb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output pteb_pkg::cfg_t                   cfg
);
  import pteb_pkg::*;

  logic [DT_W-1:0]          time_step;
  logic signed [DATA_W-1:0] wall_x_min;
  logic signed [DATA_W-1:0] wall_x_max;
  logic signed [DATA_W-1:0] wall_y_min;
  logic signed [DATA_W-1:0] wall_y_max;
  logic signed [DATA_W-1:0] floor_z;
  logic [RADIUS_W-1:0]      particle_radius;
  logic [REST_W-1:0]        restitution;
  logic                     wr;
  reg_idx_t                 idx;
  logic signed [SUM_W-1:0]  rad_w;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign rad_w  = SUM_W'(particle_radius);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step       <= TIME_STEP_RST;
      wall_x_min      <= WALL_X_MIN_RST;
      wall_x_max      <= WALL_X_MAX_RST;
      wall_y_min      <= WALL_Y_MIN_RST;
      wall_y_max      <= WALL_Y_MAX_RST;
      floor_z         <= FLOOR_Z_RST;
      particle_radius <= RADIUS_RST;
      restitution     <= REST_RST;
    end else if (wr) begin
      case (idx)
        REG_TIME_STEP:   time_step       <= pwdata[DT_W-1:0];
        REG_WALL_X_MIN:  wall_x_min      <= pwdata;
        REG_WALL_X_MAX:  wall_x_max      <= pwdata;
        REG_WALL_Y_MIN:  wall_y_min      <= pwdata;
        REG_WALL_Y_MAX:  wall_y_max      <= pwdata;
        REG_FLOOR_Z:     floor_z         <= pwdata;
        REG_RADIUS:      particle_radius <= pwdata[RADIUS_W-1:0];
        REG_RESTITUTION: restitution     <= pwdata[REST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIME_STEP:   prdata = 32'(time_step);
      REG_WALL_X_MIN:  prdata = wall_x_min;
      REG_WALL_X_MAX:  prdata = wall_x_max;
      REG_WALL_Y_MIN:  prdata = wall_y_min;
      REG_WALL_Y_MAX:  prdata = wall_y_max;
      REG_FLOOR_Z:     prdata = floor_z;
      REG_RADIUS:      prdata = 32'(particle_radius);
      REG_RESTITUTION: prdata = 32'(restitution);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    cfg.dt       <= time_step;
    cfg.rest     <= restitution;
    cfg.lim_x_lo <= sat32(SUM_W'(wall_x_min) + rad_w);
    cfg.lim_x_hi <= sat32(SUM_W'(wall_x_max) - rad_w);
    cfg.lim_y_lo <= sat32(SUM_W'(wall_y_min) + rad_w);
    cfg.lim_y_hi <= sat32(SUM_W'(wall_y_max) - rad_w);
    cfg.lim_z_lo <= sat32(SUM_W'(floor_z) + rad_w);
  end

endmodule
`default_nettype wire
